FILE: rtl/lam_pkg.sv
`timescale 1ns / 1ps

package lam_pkg;

    localparam int MAX_RES     = 8;
    localparam int CNT_W       = 4;
    localparam int PC_W        = 5;
    localparam int SP_W        = 4;
    localparam int STACK_DEPTH = 8;

    localparam logic [2:0] ST_BEGIN      = 3'd0;
    localparam logic [2:0] ST_DETACHED   = 3'd1;
    localparam logic [2:0] ST_WAITING    = 3'd2;
    localparam logic [2:0] ST_ATTACHED   = 3'd3;
    localparam logic [2:0] ST_COLLECTING = 3'd4;
    localparam logic [2:0] ST_COLLDIST   = 3'd5;
    localparam logic [2:0] NX_KEEP       = 3'd7;

    localparam logic [3:0] EV_E1 = 4'd0;
    localparam logic [3:0] EV_E2 = 4'd1;
    localparam logic [3:0] EV_E3 = 4'd2;
    localparam logic [3:0] EV_E4 = 4'd3;
    localparam logic [3:0] EV_E5 = 4'd4;
    localparam logic [3:0] EV_E6 = 4'd5;
    localparam logic [3:0] EV_E7 = 4'd6;
    localparam logic [3:0] EV_E8 = 4'd7;
    localparam logic [3:0] EV_E9 = 4'd8;

    localparam logic [2:0] ACT_DETACH   = 3'd0;
    localparam logic [2:0] ACT_WAIT     = 3'd1;
    localparam logic [2:0] ACT_ATTACH   = 3'd2;
    localparam logic [2:0] ACT_COLLECT  = 3'd3;
    localparam logic [2:0] ACT_COLLDIST = 3'd4;

    localparam logic [1:0] SEL_UNSELECTED = 2'd0;
    localparam logic [1:0] SEL_SELECTED   = 2'd1;
    localparam logic [1:0] SEL_STANDBY    = 2'd2;

    // microcode routine entry points
    localparam logic [PC_W-1:0] PC_DISPATCH  = 5'd0;
    localparam logic [PC_W-1:0] PC_DETACHED  = 5'd1;
    localparam logic [PC_W-1:0] PC_WAITING   = 5'd5;
    localparam logic [PC_W-1:0] PC_ATTACHED  = 5'd9;
    localparam logic [PC_W-1:0] PC_COLLECT   = 5'd14;
    localparam logic [PC_W-1:0] PC_COLLDIST  = 5'd20;

    typedef enum logic [1:0] {
        OP_DISPATCH = 2'd0,
        OP_ENTER    = 2'd1,
        OP_CHECK    = 2'd2,
        OP_RET      = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        C_ALWAYS     = 4'd0,
        C_SEL0       = 4'd1,
        C_SEL1       = 4'd2,
        C_SEL2       = 4'd3,
        C_WAIT_RDY   = 4'd4,
        C_PSYNC_SEL1 = 4'd5,
        C_NOT_PSYNC  = 4'd6,
        C_COLL_E8    = 4'd7,
        C_COLL_E9    = 4'd8
    } cond_t;

    typedef struct packed {
        op_t        op;
        cond_t      cond;
        logic [3:0] ev;
        logic [2:0] act;
    } uword_t;

    typedef struct packed {
        logic   load_in;
        logic   take;
        logic   enter;
        logic   flush;
        uword_t uw;
    } ctl_t;

    typedef struct packed {
        logic       trans_ok;
        logic [2:0] nx;
        logic       room;
    } stat_t;

    typedef struct packed {
        logic [2:0] new_state;
        logic [2:0] state_action;
        logic       attach_request;
        logic       detach_request;
        logic       actor_sync;
        logic       actor_collecting;
        logic       actor_distributing;
        logic       transmit_request;
    } res_t;

    function automatic logic [2:0] next_state(input logic [3:0] ev, input logic [2:0] st);
        logic [2:0] nx;
        nx = NX_KEEP;
        case (ev) inside
            EV_E1: if (st == ST_DETACHED) nx = ST_WAITING;
            EV_E2:
            begin
                if (st == ST_WAITING || st == ST_ATTACHED) nx = ST_DETACHED;
                if (st == ST_COLLECTING || st == ST_COLLDIST) nx = ST_ATTACHED;
            end
            EV_E3: if (st == ST_WAITING) nx = ST_ATTACHED;
            EV_E4:
            begin
                if (st == ST_ATTACHED) nx = ST_DETACHED;
                if (st == ST_COLLECTING || st == ST_COLLDIST) nx = ST_ATTACHED;
            end
            EV_E5: if (st == ST_ATTACHED) nx = ST_COLLECTING;
            EV_E6, EV_E9:
            begin
                if (st == ST_COLLECTING || st == ST_COLLDIST) nx = ST_ATTACHED;
            end
            EV_E7: if (st <= ST_COLLDIST) nx = ST_DETACHED;
            EV_E8: if (st == ST_COLLECTING) nx = ST_COLLDIST;
            default: nx = NX_KEEP;
        endcase
        return nx;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] st);
        logic [PC_W-1:0] pc;
        unique case (st)
            ST_DETACHED:   pc = PC_DETACHED;
            ST_WAITING:    pc = PC_WAITING;
            ST_ATTACHED:   pc = PC_ATTACHED;
            ST_COLLECTING: pc = PC_COLLECT;
            ST_COLLDIST:   pc = PC_COLLDIST;
            default:       pc = PC_DISPATCH;
        endcase
        return pc;
    endfunction

endpackage

FILE: rtl/lam_rom.sv
`timescale 1ns / 1ps

module lam_rom
    import lam_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output uword_t          uw
);

    always_comb
    begin
        unique case (pc)
            5'd0:  uw = '{OP_DISPATCH, C_ALWAYS,     EV_E1, ACT_DETACH};
            // detached
            5'd1:  uw = '{OP_ENTER,    C_ALWAYS,     EV_E1, ACT_DETACH};
            5'd2:  uw = '{OP_CHECK,    C_SEL1,       EV_E1, ACT_DETACH};
            5'd3:  uw = '{OP_CHECK,    C_SEL2,       EV_E4, ACT_DETACH};
            5'd4:  uw = '{OP_RET,      C_ALWAYS,     EV_E1, ACT_DETACH};
            // waiting
            5'd5:  uw = '{OP_ENTER,    C_ALWAYS,     EV_E1, ACT_WAIT};
            5'd6:  uw = '{OP_CHECK,    C_SEL0,       EV_E2, ACT_WAIT};
            5'd7:  uw = '{OP_CHECK,    C_WAIT_RDY,   EV_E3, ACT_WAIT};
            5'd8:  uw = '{OP_RET,      C_ALWAYS,     EV_E1, ACT_WAIT};
            // attached
            5'd9:  uw = '{OP_ENTER,    C_ALWAYS,     EV_E1, ACT_ATTACH};
            5'd10: uw = '{OP_CHECK,    C_SEL0,       EV_E2, ACT_ATTACH};
            5'd11: uw = '{OP_CHECK,    C_SEL2,       EV_E4, ACT_ATTACH};
            5'd12: uw = '{OP_CHECK,    C_PSYNC_SEL1, EV_E5, ACT_ATTACH};
            5'd13: uw = '{OP_RET,      C_ALWAYS,     EV_E1, ACT_ATTACH};
            // collecting
            5'd14: uw = '{OP_ENTER,    C_ALWAYS,     EV_E1, ACT_COLLECT};
            5'd15: uw = '{OP_CHECK,    C_SEL0,       EV_E2, ACT_COLLECT};
            5'd16: uw = '{OP_CHECK,    C_SEL2,       EV_E4, ACT_COLLECT};
            5'd17: uw = '{OP_CHECK,    C_NOT_PSYNC,  EV_E6, ACT_COLLECT};
            5'd18: uw = '{OP_CHECK,    C_COLL_E8,    EV_E8, ACT_COLLECT};
            5'd19: uw = '{OP_RET,      C_ALWAYS,     EV_E1, ACT_COLLECT};
            // collecting and distributing
            5'd20: uw = '{OP_ENTER,    C_ALWAYS,     EV_E1, ACT_COLLDIST};
            5'd21: uw = '{OP_CHECK,    C_SEL0,       EV_E2, ACT_COLLDIST};
            5'd22: uw = '{OP_CHECK,    C_SEL2,       EV_E4, ACT_COLLDIST};
            5'd23: uw = '{OP_CHECK,    C_NOT_PSYNC,  EV_E6, ACT_COLLDIST};
            5'd24: uw = '{OP_CHECK,    C_COLL_E9,    EV_E9, ACT_COLLDIST};
            default: uw = '{OP_RET,    C_ALWAYS,     EV_E1, ACT_DETACH};
        endcase
    end

endmodule

FILE: rtl/lam_seq.sv
`timescale 1ns / 1ps

module lam_seq
    import lam_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output ctl_t  ctl
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_RUN   = 3'b010,
        PH_FLUSH = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PC_W-1:0]   stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]   sp_dec;
    logic              push;
    logic              running;
    logic              cnt_full;
    logic              take;
    uword_t            uw;

    lam_rom u_rom
    (
        .pc (pc_reg),
        .uw (uw)
    );

    assign running  = (phase_reg == PH_RUN);
    assign cnt_full = (cnt_reg == CNT_W'(MAX_RES));
    assign take     = running && (uw.op == OP_DISPATCH || uw.op == OP_CHECK)
                      && stat.trans_ok && !cnt_full;
    assign sp_dec   = sp_reg - 1'b1;
    assign push     = take && (uw.op == OP_CHECK);
    assign in_stall = (phase_reg != PH_IDLE);

    always_comb
    begin
        ctl.load_in = (phase_reg == PH_IDLE) && in_valid;
        ctl.take    = take;
        ctl.enter   = running && (uw.op == OP_ENTER) && stat.room;
        ctl.flush   = (phase_reg == PH_FLUSH);
        ctl.uw      = uw;
    end

    always_comb
    begin
        phase_next = phase_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    phase_next = PH_RUN;
                    pc_next    = PC_DISPATCH;
                    sp_next    = '0;
                    cnt_next   = '0;
                end
            end
            PH_RUN:
            begin
                unique case (uw.op) inside
                    OP_DISPATCH, OP_CHECK:
                    begin
                        if (take)
                        begin
                            pc_next  = entry_pc(stat.nx);
                            cnt_next = cnt_reg + 1'b1;
                            if (push)
                                sp_next = sp_reg + 1'b1;
                        end
                        else if (uw.op == OP_DISPATCH)
                            phase_next = PH_FLUSH;
                        else
                            pc_next = pc_reg + 1'b1;
                    end
                    OP_ENTER:
                    begin
                        if (stat.room)
                            pc_next = pc_reg + 1'b1;
                    end
                    OP_RET:
                    begin
                        if (sp_reg == '0)
                            phase_next = PH_FLUSH;
                        else
                        begin
                            sp_next = sp_dec;
                            pc_next = stack_reg[sp_dec[SP_W-2:0]];
                        end
                    end
                    default: phase_next = PH_FLUSH;
                endcase
            end
            PH_FLUSH:
            begin
                if (stat.room)
                    phase_next = PH_IDLE;
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pc_reg    <= PC_DISPATCH;
            sp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            stack_reg[sp_reg[SP_W-2:0]] <= pc_reg + 1'b1;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("return stack overflow");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_RES))
        else $error("result count past bound");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (sp_reg == '0))
        else $error("idle with return stack not empty");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("nested entry without count");

endmodule

FILE: rtl/lam_dp.sv
`timescale 1ns / 1ps

module lam_dp
    import lam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] action,
    input  logic [1:0] selected,
    input  logic       lag_present,
    input  logic       lag_ready,
    input  logic       partner_sync,
    input  logic       partner_collecting,
    input  logic       coll_enabled,
    input  ctl_t       ctl,
    output stat_t      stat,
    input  logic       out_stall,
    output logic       out_valid,
    output res_t       out_res,
    output logic       out_last
);

    logic [3:0] ev_in_reg;
    logic [1:0] sel_reg;
    logic       lag_reg, rdy_reg, psync_reg, pcoll_reg, hwcoll_reg;

    logic [2:0] mux_reg, prev_reg;
    logic       sync_reg, coll_reg, dist_reg;
    logic       sync_next, coll_next, dist_next;

    res_t       pend_reg, pend_next;
    logic       pend_valid_reg;
    res_t       out_res_reg;
    logic       out_last_reg, out_valid_reg;

    logic [3:0] ev_sel;
    logic [2:0] nx;
    logic       cond_true;
    logic       out_free;
    logic       load_out;
    logic       load_last;

    assign ev_sel = (ctl.uw.op == OP_DISPATCH) ? ev_in_reg : ctl.uw.ev;
    assign nx     = next_state(ev_sel, mux_reg);

    always_comb
    begin
        case (ctl.uw.cond)
            C_ALWAYS:     cond_true = 1'b1;
            C_SEL0:       cond_true = (sel_reg == SEL_UNSELECTED);
            C_SEL1:       cond_true = (sel_reg == SEL_SELECTED);
            C_SEL2:       cond_true = (sel_reg == SEL_STANDBY);
            C_WAIT_RDY:   cond_true = (sel_reg == SEL_SELECTED) && lag_reg && rdy_reg;
            C_PSYNC_SEL1: cond_true = (sel_reg == SEL_SELECTED) && psync_reg;
            C_NOT_PSYNC:  cond_true = !psync_reg;
            C_COLL_E8:    cond_true = (sel_reg == SEL_SELECTED) && psync_reg
                                      && pcoll_reg && coll_reg;
            C_COLL_E9:    cond_true = psync_reg && !pcoll_reg;
            default:      cond_true = 1'b0;
        endcase
    end

    assign out_free   = !out_valid_reg || !out_stall;
    assign stat.trans_ok = cond_true && (nx != NX_KEEP);
    assign stat.nx    = nx;
    assign stat.room  = !pend_valid_reg || out_free;

    always_comb
    begin
        sync_next = sync_reg;
        coll_next = coll_reg;
        dist_next = dist_reg;
        pend_next = '0;
        case (ctl.uw.act)
            ACT_DETACH:
            begin
                sync_next = 1'b0;
                coll_next = 1'b0;
                dist_next = 1'b0;
                pend_next.detach_request = lag_reg;
            end
            ACT_ATTACH:
            begin
                sync_next = 1'b1;
                coll_next = 1'b0;
                dist_next = 1'b0;
                pend_next.attach_request = (prev_reg != ST_COLLECTING)
                                           && (prev_reg != ST_COLLDIST) && lag_reg;
            end
            ACT_COLLECT:
            begin
                dist_next = 1'b0;
                coll_next = hwcoll_reg;
            end
            ACT_COLLDIST: dist_next = 1'b1;
            default: ;
        endcase
        pend_next.new_state          = mux_reg;
        pend_next.state_action       = ctl.uw.act;
        pend_next.actor_sync         = sync_next;
        pend_next.actor_collecting   = coll_next;
        pend_next.actor_distributing = dist_next;
        pend_next.transmit_request   = (ctl.uw.act != ACT_WAIT);
    end

    // a held result moves out when the next one is made or the chain ends
    assign load_out  = pend_valid_reg && out_free && (ctl.enter || ctl.flush);
    assign load_last = ctl.flush;

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            ev_in_reg  <= action;
            sel_reg    <= selected;
            lag_reg    <= lag_present;
            rdy_reg    <= lag_ready;
            psync_reg  <= partner_sync;
            pcoll_reg  <= partner_collecting;
            hwcoll_reg <= coll_enabled;
        end
        if (ctl.enter)
            pend_reg <= pend_next;
        if (load_out)
        begin
            out_res_reg  <= pend_reg;
            out_last_reg <= load_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mux_reg        <= ST_BEGIN;
            prev_reg       <= ST_BEGIN;
            sync_reg       <= 1'b0;
            coll_reg       <= 1'b0;
            dist_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.take)
            begin
                prev_reg <= mux_reg;
                mux_reg  <= nx;
            end
            if (ctl.enter)
            begin
                sync_reg <= sync_next;
                coll_reg <= coll_next;
                dist_reg <= dist_next;
            end
            if (ctl.enter)
                pend_valid_reg <= 1'b1;
            else if (load_out)
                pend_valid_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.enter && pend_valid_reg) |-> out_free)
        else $error("held result lost");

    a_enter_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |=> (mux_reg != ST_BEGIN))
        else $error("transition into begin state");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=>
            (out_valid_reg && $stable(out_res_reg) && $stable(out_last_reg)))
        else $error("stalled result beat changed");

endmodule

FILE: rtl/link_aggregation_mux_fsm.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_valid / in_stall  action, selected, lag_present, lag_ready,
//                                partner_sync, partner_collecting, coll_enabled
// output    out_valid/out_stall  new_state, state_action, attach_request,
//                                detach_request, actor_sync, actor_collecting,
//                                actor_distributing, transmit_request, last
//
// One event at a time: the idle phase takes the beat, a dispatch step follows, then per
// entered state a routine of enter, checks and return runs, then a flush step ends it.
// Output stall holds the sequencer only when a new result or the flush finds the held
// one unsent. Reset returns the mux to begin with all actor bits cleared.

module link_aggregation_mux_fsm
    import lam_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [3:0] action,
    input  logic [1:0] selected,
    input  logic       lag_present,
    input  logic       lag_ready,
    input  logic       partner_sync,
    input  logic       partner_collecting,
    input  logic       coll_enabled,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] new_state,
    output logic [2:0] state_action,
    output logic       attach_request,
    output logic       detach_request,
    output logic       actor_sync,
    output logic       actor_collecting,
    output logic       actor_distributing,
    output logic       transmit_request,
    output logic       last
);

    ctl_t  ctl;
    stat_t stat;
    res_t  res;

    lam_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    lam_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .action             (action),
        .selected           (selected),
        .lag_present        (lag_present),
        .lag_ready          (lag_ready),
        .partner_sync       (partner_sync),
        .partner_collecting (partner_collecting),
        .coll_enabled       (coll_enabled),
        .ctl                (ctl),
        .stat               (stat),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .out_res            (res),
        .out_last           (last)
    );

    assign new_state          = res.new_state;
    assign state_action       = res.state_action;
    assign attach_request     = res.attach_request;
    assign detach_request     = res.detach_request;
    assign actor_sync         = res.actor_sync;
    assign actor_collecting   = res.actor_collecting;
    assign actor_distributing = res.actor_distributing;
    assign transmit_request   = res.transmit_request;

endmodule

FILE: sim/link_aggregation_mux_fsm_tb.sv
`timescale 1ns / 1ps

module link_aggregation_mux_fsm_tb
    import lam_pkg::*;
();

    localparam int         STALL_LIMIT = 3000;
    localparam int         DRAIN_WAIT  = 60;
    localparam logic [3:0] EV_BAD_LO   = 4'd9;
    localparam logic [3:0] EV_BAD_HI   = 4'd15;
    localparam logic [1:0] SEL_CODE3   = 2'd3;

    typedef struct packed {
        logic [2:0] st;
        logic [2:0] act;
        logic       att;
        logic       det;
        logic       sync;
        logic       coll;
        logic       distr;
        logic       tx;
        logic       last;
    } mux_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [3:0] action = '0;
    logic [1:0] selected = '0;
    logic       lag_present = 1'b0;
    logic       lag_ready = 1'b0;
    logic       partner_sync = 1'b0;
    logic       partner_collecting = 1'b0;
    logic       coll_enabled = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] new_state;
    logic [2:0] state_action;
    logic       attach_request;
    logic       detach_request;
    logic       actor_sync;
    logic       actor_collecting;
    logic       actor_distributing;
    logic       transmit_request;
    logic       last;

    // predicted mux state
    logic [2:0] mux_st = ST_BEGIN;
    logic [2:0] prev_st = ST_BEGIN;
    logic       sync_q = 1'b0;
    logic       coll_q = 1'b0;
    logic       dist_q = 1'b0;

    mux_beat_t  chain_q[$];
    mux_beat_t  beat_q[$];

    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;
    int         errors = 0;
    int         events_sent = 0;
    int         beats_checked = 0;
    int         longest_chain = 0;
    int         idle_cycles = 0;
    logic [7:0] states_seen = '0;

    link_aggregation_mux_fsm dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .selected          (selected),
        .lag_present       (lag_present),
        .lag_ready         (lag_ready),
        .partner_sync      (partner_sync),
        .partner_collecting(partner_collecting),
        .coll_enabled      (coll_enabled),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .new_state         (new_state),
        .state_action      (state_action),
        .attach_request    (attach_request),
        .detach_request    (detach_request),
        .actor_sync        (actor_sync),
        .actor_collecting  (actor_collecting),
        .actor_distributing(actor_distributing),
        .transmit_request  (transmit_request),
        .last              (last)
    );

    always #1 clk = ~clk;

    function automatic logic [2:0] mux_next(input logic [3:0] ev, input logic [2:0] st);
        logic [2:0] nx;
        nx = NX_KEEP;
        if (ev == EV_E7 && st <= ST_COLLDIST)
            nx = ST_DETACHED;
        else
        begin
            case (st) inside
                ST_DETACHED:
                    if (ev == EV_E1) nx = ST_WAITING;
                ST_WAITING:
                begin
                    if (ev == EV_E2) nx = ST_DETACHED;
                    if (ev == EV_E3) nx = ST_ATTACHED;
                end
                ST_ATTACHED:
                begin
                    if (ev == EV_E2 || ev == EV_E4) nx = ST_DETACHED;
                    if (ev == EV_E5) nx = ST_COLLECTING;
                end
                ST_COLLECTING, ST_COLLDIST:
                begin
                    if (ev == EV_E2 || ev == EV_E4 || ev == EV_E6 || ev == EV_E9)
                        nx = ST_ATTACHED;
                    if (ev == EV_E8 && st == ST_COLLECTING) nx = ST_COLLDIST;
                end
                default: nx = NX_KEEP;
            endcase
        end
        return nx;
    endfunction

    function automatic int exit_count(input logic [2:0] st);
        case (st) inside
            ST_DETACHED, ST_WAITING: return 2;
            ST_ATTACHED:             return 3;
            ST_COLLECTING, ST_COLLDIST: return 4;
            default:                 return 0;
        endcase
    endfunction

    // k-th exit condition of a state's routine, in routine order
    function automatic logic exit_hit(input logic [2:0] st, input int k, input logic [1:0] sel,
                                      input logic lag, input logic rdy, input logic ps,
                                      input logic pc, output logic [3:0] ev);
        logic hit;
        hit = 1'b0;
        ev = EV_E1;
        case (st) inside
            ST_DETACHED:
                case (k)
                    0:
                    begin
                        hit = (sel == SEL_SELECTED);
                        ev = EV_E1;
                    end
                    1:
                    begin
                        hit = (sel == SEL_STANDBY);
                        ev = EV_E4;
                    end
                    default: hit = 1'b0;
                endcase
            ST_WAITING:
                case (k)
                    0:
                    begin
                        hit = (sel == SEL_UNSELECTED);
                        ev = EV_E2;
                    end
                    1:
                    begin
                        hit = (sel == SEL_SELECTED) && lag && rdy;
                        ev = EV_E3;
                    end
                    default: hit = 1'b0;
                endcase
            ST_ATTACHED:
                case (k)
                    0:
                    begin
                        hit = (sel == SEL_UNSELECTED);
                        ev = EV_E2;
                    end
                    1:
                    begin
                        hit = (sel == SEL_STANDBY);
                        ev = EV_E4;
                    end
                    2:
                    begin
                        hit = ps && (sel == SEL_SELECTED);
                        ev = EV_E5;
                    end
                    default: hit = 1'b0;
                endcase
            ST_COLLECTING, ST_COLLDIST:
                case (k)
                    0:
                    begin
                        hit = (sel == SEL_UNSELECTED);
                        ev = EV_E2;
                    end
                    1:
                    begin
                        hit = (sel == SEL_STANDBY);
                        ev = EV_E4;
                    end
                    2:
                    begin
                        hit = !ps;
                        ev = EV_E6;
                    end
                    3:
                    begin
                        if (st == ST_COLLECTING)
                        begin
                            hit = (sel == SEL_SELECTED) && ps && pc && coll_q;
                            ev = EV_E8;
                        end
                        else
                        begin
                            hit = ps && !pc;
                            ev = EV_E9;
                        end
                    end
                    default: hit = 1'b0;
                endcase
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // apply one event to the predicted mux; returns 1 when a state was entered
    function automatic logic take_event(input logic [3:0] ev, input logic lag, input logic hw);
        logic [2:0] nx;
        mux_beat_t  b;
        if (chain_q.size() >= MAX_RES) return 1'b0;
        nx = mux_next(ev, mux_st);
        if (nx == NX_KEEP) return 1'b0;
        prev_st = mux_st;
        mux_st = nx;
        b = '0;
        b.st = nx;
        b.tx = 1'b1;
        case (nx)
            ST_DETACHED:
            begin
                sync_q = 1'b0;
                coll_q = 1'b0;
                dist_q = 1'b0;
                b.act = ACT_DETACH;
                b.det = lag;
            end
            ST_WAITING:
            begin
                b.act = ACT_WAIT;
                b.tx = 1'b0;
            end
            ST_ATTACHED:
            begin
                b.att = (prev_st != ST_COLLECTING) && (prev_st != ST_COLLDIST) && lag;
                sync_q = 1'b1;
                coll_q = 1'b0;
                dist_q = 1'b0;
                b.act = ACT_ATTACH;
            end
            ST_COLLECTING:
            begin
                dist_q = 1'b0;
                coll_q = hw;
                b.act = ACT_COLLECT;
            end
            default:
            begin
                dist_q = 1'b1;
                b.act = ACT_COLLDIST;
            end
        endcase
        b.sync = sync_q;
        b.coll = coll_q;
        b.distr = dist_q;
        chain_q.push_back(b);
        return 1'b1;
    endfunction

    // walk the chain of entered states with an explicit stack of routines
    task automatic predict_chain(input logic [3:0] a, input logic [1:0] sel, input logic lag,
                                 input logic rdy, input logic ps, input logic pc,
                                 input logic hw);
        logic [2:0] frame_st[0:MAX_RES];
        int         frame_ck[0:MAX_RES];
        int         depth;
        int         k;
        logic [3:0] ev;
        mux_beat_t  b;
        chain_q.delete();
        depth = 0;
        if (a <= EV_E9 && take_event(a, lag, hw))
        begin
            frame_st[0] = mux_st;
            frame_ck[0] = 0;
            depth = 1;
        end
        while (depth > 0)
        begin
            k = frame_ck[depth-1];
            frame_ck[depth-1] = k + 1;
            if (k >= exit_count(frame_st[depth-1]))
                depth--;
            else if (exit_hit(frame_st[depth-1], k, sel, lag, rdy, ps, pc, ev) &&
                     take_event(ev, lag, hw))
            begin
                frame_st[depth] = mux_st;
                frame_ck[depth] = 0;
                depth++;
            end
        end
        if (chain_q.size() > longest_chain) longest_chain = chain_q.size();
        for (int i = 0; i < chain_q.size(); i++)
        begin
            b = chain_q[i];
            b.last = (i == chain_q.size() - 1);
            beat_q.push_back(b);
        end
    endtask

    task automatic send_event(input logic [3:0] a, input logic [1:0] sel, input logic lag,
                              input logic rdy, input logic ps, input logic pc,
                              input logic hw);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        selected <= sel;
        lag_present <= lag;
        lag_ready <= rdy;
        partner_sync <= ps;
        partner_collecting <= pc;
        coll_enabled <= hw;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_chain(a, sel, lag, rdy, ps, pc, hw);
        events_sent++;
    endtask

    task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        mux_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (beat_q.size() == 0)
            begin
                $error("unexpected result beat: new_state %0d", new_state);
                errors++;
            end
            else
            begin
                want = beat_q.pop_front();
                check_field("new_state", want.st, new_state);
                check_field("state_action", want.act, state_action);
                check_field("attach_request", want.att, attach_request);
                check_field("detach_request", want.det, detach_request);
                check_field("actor_sync", want.sync, actor_sync);
                check_field("actor_collecting", want.coll, actor_collecting);
                check_field("actor_distributing", want.distr, actor_distributing);
                check_field("transmit_request", want.tx, transmit_request);
                check_field("last", want.last, last);
            end
            beats_checked++;
            states_seen[new_state] = 1'b1;
        end
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_begin_state;
        send_event(EV_E1, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E9, SEL_SELECTED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(EV_BAD_HI, SEL_UNSELECTED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(EV_E7, SEL_UNSELECTED, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_full_bringup;
        send_event(EV_E7, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E9, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        send_event(EV_E6, SEL_SELECTED, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        send_event(EV_E5, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E8, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E2, SEL_UNSELECTED, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
    endtask

    task automatic test_standby;
        send_event(EV_E7, SEL_STANDBY, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E1, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E4, SEL_STANDBY, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E3, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_waiting_exits;
        send_event(EV_E1, SEL_SELECTED, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E3, SEL_SELECTED, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1);
        send_event(EV_E7, SEL_SELECTED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_event(EV_E2, SEL_UNSELECTED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_odd_codes;
        send_event(EV_E7, SEL_CODE3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_BAD_LO, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_BAD_HI, SEL_CODE3, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_event(EV_E7, SEL_SELECTED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        send_event(EV_E9, SEL_CODE3, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
    endtask

    // mostly selected with flags set, so chains climb toward collecting and distributing
    task automatic test_random(input int n, input int snd_pct, input int rcv_pct);
        int         r;
        logic [3:0] a;
        logic [1:0] sel;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                a = EV_E7;
            else if (r < 16)
                a = 4'($urandom_range(EV_BAD_LO, EV_BAD_HI));
            else
                a = 4'($urandom_range(EV_E1, EV_E9));
            r = $urandom_range(0, 99);
            if (r < 55)
                sel = SEL_SELECTED;
            else if (r < 72)
                sel = SEL_UNSELECTED;
            else if (r < 89)
                sel = SEL_STANDBY;
            else
                sel = SEL_CODE3;
            send_event(a, sel, $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 75,
                       $urandom_range(0, 99) < 75, $urandom_range(0, 99) < 70,
                       $urandom_range(0, 99) < 75);
        end
    endtask

    initial
    begin
        snd_idle_pct = 24;
        rcv_idle_pct = 58;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_begin_state();
        test_full_bringup();
        test_standby();
        test_waiting_exits();
        test_odd_codes();
        test_random(110, 24, 58);
        test_random(110, 58, 24);
        test_random(100, 0, 0);
        in_valid <= 1'b0;
        while (beat_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d events and %0d result beats, longest chain %0d states.",
                 events_sent, beats_checked, longest_chain);
        $display("States entered (bit per code): %b", states_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: link_aggregation_mux_fsm.f
rtl/lam_pkg.sv
rtl/lam_rom.sv
rtl/lam_seq.sv
rtl/lam_dp.sv
rtl/link_aggregation_mux_fsm.sv
sim/link_aggregation_mux_fsm_tb.sv
